@@ hw/rtl/pced_pkg.sv @@
// Shared types, constants and functions for the contact energy delta block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pced_pkg;

   localparam int NEIGHBOR_COUNT = 8;
   localparam int TAG_WIDTH      = 8;
   localparam int KIND_WIDTH     = 2;
   localparam int ENERGY_WIDTH   = 16;
   localparam int DIFF_WIDTH     = ENERGY_WIDTH + 1;
   localparam int PART_WIDTH     = DIFF_WIDTH + 1;
   localparam int DELTA_WIDTH    = 20;
   localparam int CSR_ADDR_WIDTH = 8;

   typedef logic [KIND_WIDTH-1:0]     kind_type;
   typedef logic [ENERGY_WIDTH-1:0]   energy_word_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   localparam kind_type KIND_CM = 2'd1;

   localparam csr_addr_type REG_CM_CM      = 8'd0;
   localparam csr_addr_type REG_FB_FB      = 8'd1;
   localparam csr_addr_type REG_FB_CM      = 8'd2;
   localparam csr_addr_type REG_CM_MEDIUM  = 8'd3;
   localparam csr_addr_type REG_FB_MEDIUM  = 8'd4;

   typedef enum logic [2:0] {
      PAIR_NONE,
      PAIR_CM_CM,
      PAIR_FB_FB,
      PAIR_FB_CM,
      PAIR_CM_MEDIUM,
      PAIR_FB_MEDIUM
   } pair_type;

   typedef struct packed {
      energy_word_type cm_cm;
      energy_word_type fb_fb;
      energy_word_type fb_cm;
      energy_word_type cm_medium;
      energy_word_type fb_medium;
   } energy_type;

   function automatic pair_type pair_class(input logic [TAG_WIDTH-1:0] tag_a,
                                           input logic [TAG_WIDTH-1:0] tag_b,
                                           input kind_type kind_a,
                                           input kind_type kind_b);
      pair_type code;
      kind_type cell_kind;
      code = PAIR_NONE;
      cell_kind = kind_a;
      if (tag_a == tag_b) begin
         code = PAIR_NONE;
      end else if (tag_a == '0 || tag_b == '0) begin
         cell_kind = (tag_a == '0) ? kind_b : kind_a;
         code = (cell_kind == KIND_CM) ? PAIR_CM_MEDIUM : PAIR_FB_MEDIUM;
      end else if (kind_a == kind_b) begin
         code = (kind_a == KIND_CM) ? PAIR_CM_CM : PAIR_FB_FB;
      end else begin
         code = PAIR_FB_CM;
      end
      return code;
   endfunction

   function automatic energy_word_type energy_lookup(input pair_type code,
                                                     input energy_type energy);
      energy_word_type value;
      case (code)
         PAIR_CM_CM:     value = energy.cm_cm;
         PAIR_FB_FB:     value = energy.fb_fb;
         PAIR_FB_CM:     value = energy.fb_cm;
         PAIR_CM_MEDIUM: value = energy.cm_medium;
         PAIR_FB_MEDIUM: value = energy.fb_medium;
         default:        value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pced_if.sv @@
// Channel interfaces of the contact energy delta block: request, response, CSR write.
// Depends on pced_pkg for field widths.
`default_nettype none

interface pced_req_if;
   logic                                                 valid;
   logic                                                 ready;
   logic [pced_pkg::TAG_WIDTH-1:0]                       target_tag;
   logic [pced_pkg::KIND_WIDTH-1:0]                      target_type;
   logic [pced_pkg::TAG_WIDTH-1:0]                       source_tag;
   logic [pced_pkg::KIND_WIDTH-1:0]                      source_type;
   logic [pced_pkg::NEIGHBOR_COUNT*pced_pkg::TAG_WIDTH-1:0]  neighbor_tags;
   logic [pced_pkg::NEIGHBOR_COUNT*pced_pkg::KIND_WIDTH-1:0] neighbor_types;

   modport source (output valid, target_tag, target_type, source_tag, source_type,
                   neighbor_tags, neighbor_types, input ready);
   modport sink (input valid, target_tag, target_type, source_tag, source_type,
                 neighbor_tags, neighbor_types, output ready);
endinterface

interface pced_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pced_pkg::DELTA_WIDTH-1:0] energy_delta;

   modport source (output valid, energy_delta, input ready);
   modport sink (input valid, energy_delta, output ready);
endinterface

interface pced_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pced_pkg::CSR_ADDR_WIDTH-1:0] addr;
   logic [pced_pkg::ENERGY_WIDTH-1:0]   data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/potts_contact_energy_delta.sv @@
// An accepted request passes the code, diff, part and delta registers to the response channel.
// Throughput: one word per cycle through four register stages; a stall at the response
// holds each stage in place through a per-stage ready chain.
// Reset clears the stage valid bits and sets all five adhesion energies to zero.
// Top level of the contact energy delta block; uses pced_pkg, pced_if, pced_csr, pced_pipe.
`default_nettype none

module potts_contact_energy_delta #(
   parameter int TAG_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pced_req_if.sink    req_ch,
   pced_rsp_if.source  rsp_ch,
   pced_csr_if.sink    csr_ch
);

   pced_pkg::energy_type energy;

   pced_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_ch),
      .energy (energy)
   );

   pced_pipe #(
      .TAG_BITS (TAG_BITS)
   ) u_pipe (
      .clock  (clock),
      .reset  (reset),
      .energy (energy),
      .req    (req_ch),
      .rsp    (rsp_ch)
   );

endmodule

`default_nettype wire

@@ hw/rtl/pced_csr.sv @@
// Adhesion energy register file written through the CSR channel.
// Depends on pced_pkg and pced_if.
`default_nettype none

module pced_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   pced_csr_if.sink             csr,
   output pced_pkg::energy_type energy
);

   pced_pkg::energy_type energy_ff;
   pced_pkg::energy_type energy_in;

   assign csr.ready = 1'b1;
   assign energy = energy_ff;

   always_comb begin
      energy_in = energy_ff;
      if (csr.valid) begin
         unique case (csr.addr)
            pced_pkg::REG_CM_CM:     energy_in.cm_cm     = csr.data;
            pced_pkg::REG_FB_FB:     energy_in.fb_fb     = csr.data;
            pced_pkg::REG_FB_CM:     energy_in.fb_cm     = csr.data;
            pced_pkg::REG_CM_MEDIUM: energy_in.cm_medium = csr.data;
            pced_pkg::REG_FB_MEDIUM: energy_in.fb_medium = csr.data;
            default:                 energy_in           = energy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
      end else begin
         energy_ff <= energy_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pced_pipe.sv @@
// Four-stage pipeline: pair classification, energy difference, two adder levels.
// Depends on pced_pkg and pced_if.
`default_nettype none

module pced_pipe #(
   parameter int TAG_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pced_pkg::energy_type energy,
   pced_req_if.sink                  req,
   pced_rsp_if.source                rsp
);

   localparam int Stages = 4;
   localparam int Count  = pced_pkg::NEIGHBOR_COUNT;
   localparam int Half   = Count / 2;
   localparam int TagW   = pced_pkg::TAG_WIDTH;
   localparam int KindW  = pced_pkg::KIND_WIDTH;
   localparam int DiffW  = pced_pkg::DIFF_WIDTH;
   localparam int PartW  = pced_pkg::PART_WIDTH;
   localparam int DeltaW = pced_pkg::DELTA_WIDTH;
   localparam logic [TagW-1:0] TagMask = TagW'((1 << TAG_BITS) - 1);

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages:0]   ready;

   pced_pkg::pair_type old_code_ff [Count];
   pced_pkg::pair_type new_code_ff [Count];
   pced_pkg::pair_type old_code_in [Count];
   pced_pkg::pair_type new_code_in [Count];
   logic signed [DiffW-1:0]  diff_ff [Count];
   logic signed [DiffW-1:0]  diff_in [Count];
   logic signed [PartW-1:0]  part_ff [Half];
   logic signed [PartW-1:0]  part_in [Half];
   logic signed [DeltaW-1:0] delta_ff;
   logic signed [DeltaW-1:0] delta_in;

   logic [TagW-1:0] target_tag;
   logic [TagW-1:0] source_tag;
   logic            req_accept;
   logic            rsp_accept;

   assign target_tag = req.target_tag & TagMask;
   assign source_tag = req.source_tag & TagMask;
   assign req_accept = req.valid && req.ready;
   assign rsp_accept = rsp.valid && rsp.ready;

   always_comb begin
      ready[Stages] = rsp.ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k + 1];
      end
      valid_in[0] = ready[0] ? req.valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   assign req.ready        = ready[0];
   assign rsp.valid        = valid_ff[Stages - 1];
   assign rsp.energy_delta = delta_ff;

   always_comb begin
      for (int n = 0; n < Count; n++) begin
         old_code_in[n] = pced_pkg::pair_class(target_tag,
                                               req.neighbor_tags[TagW*n +: TagW] & TagMask,
                                               req.target_type,
                                               req.neighbor_types[KindW*n +: KindW]);
         new_code_in[n] = pced_pkg::pair_class(source_tag,
                                               req.neighbor_tags[TagW*n +: TagW] & TagMask,
                                               req.source_type,
                                               req.neighbor_types[KindW*n +: KindW]);
      end
   end

   always_comb begin
      for (int n = 0; n < Count; n++) begin
         diff_in[n] = $signed({1'b0, pced_pkg::energy_lookup(new_code_ff[n], energy)})
                    - $signed({1'b0, pced_pkg::energy_lookup(old_code_ff[n], energy)});
      end
   end

   always_comb begin
      for (int i = 0; i < Half; i++) begin
         part_in[i] = PartW'(diff_ff[2*i]) + PartW'(diff_ff[2*i + 1]);
      end
   end

   always_comb begin
      delta_in = '0;
      for (int i = 0; i < Half; i++) begin
         delta_in = delta_in + DeltaW'(part_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         old_code_ff <= old_code_in;
         new_code_ff <= new_code_in;
      end
      if (ready[1]) begin
         diff_ff <= diff_in;
      end
      if (ready[2]) begin
         part_ff <= part_in;
      end
      if (ready[3]) begin
         delta_ff <= delta_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !req_accept && !rsp_accept |=> $countones(valid_ff) == $past($countones(valid_ff)))
      else $error("Pipeline gained or lost a word without a handshake.");

   assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("Pipeline stalled its input while the output was free.");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !ready[3] |=> valid_ff[2] && $stable(part_ff[0]))
      else $error("Partial sum changed while its stage was stalled.");
`endif

endmodule

`default_nettype wire

@@ tb/tb_potts_contact_energy_delta.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for potts_contact_energy_delta: drives copy attempts and CSR writes,
// predicts each energy delta and checks it on the response channel.
// Depends on pced_pkg, pced_if and the RTL of potts_contact_energy_delta.

module tb_potts_contact_energy_delta;

   localparam int TAG_WIDTH = pced_pkg::TAG_WIDTH;
   localparam int KIND_WIDTH = pced_pkg::KIND_WIDTH;
   localparam int NEIGHBOR_COUNT = pced_pkg::NEIGHBOR_COUNT;
   localparam int DELTA_WIDTH = pced_pkg::DELTA_WIDTH;
   localparam int TAG_BITS = 8;
   localparam logic [TAG_WIDTH-1:0] TAG_MASK = TAG_WIDTH'((1 << TAG_BITS) - 1);
   localparam int REG_COUNT = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS = 112;

   typedef pced_pkg::kind_type        kind_type;
   typedef pced_pkg::energy_word_type energy_word_type;
   typedef pced_pkg::energy_type      energy_type;
   typedef pced_pkg::csr_addr_type    csr_addr_type;

   typedef enum int {
      PACE_FREE,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pacing_mode_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]                     target_tag;
      kind_type                                 target_type;
      logic [TAG_WIDTH-1:0]                     source_tag;
      kind_type                                 source_type;
      logic [NEIGHBOR_COUNT*TAG_WIDTH-1:0]      neighbor_tags;
      logic [NEIGHBOR_COUNT*KIND_WIDTH-1:0]     neighbor_types;
   } copy_attempt_type;

   logic clock;
   logic reset;

   pced_req_if req_if ();
   pced_rsp_if rsp_if ();
   pced_csr_if csr_if ();

   potts_contact_energy_delta #(
      .TAG_BITS (TAG_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   copy_attempt_type              pending_attempts[$];
   logic signed [DELTA_WIDTH-1:0] expected_deltas[$];
   energy_type                    adhesion;
   pacing_mode_type               pacing;
   logic                          req_taken;
   int                            mismatch_count;
   int                            attempts_accepted;
   int                            deltas_checked;
   int                            settings_programmed;

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   function automatic energy_word_type contact_cost(input logic [TAG_WIDTH-1:0] tag_a,
                                                    input logic [TAG_WIDTH-1:0] tag_b,
                                                    input kind_type kind_a,
                                                    input kind_type kind_b);
      kind_type cell_kind;
      if (tag_a == tag_b) begin
         return '0;
      end
      if (tag_a == '0 || tag_b == '0) begin
         cell_kind = (tag_a == '0) ? kind_b : kind_a;
         return (cell_kind == pced_pkg::KIND_CM) ? adhesion.cm_medium : adhesion.fb_medium;
      end
      if (kind_a == kind_b) begin
         return (kind_a == pced_pkg::KIND_CM) ? adhesion.cm_cm : adhesion.fb_fb;
      end
      return adhesion.fb_cm;
   endfunction

   function automatic logic signed [DELTA_WIDTH-1:0] predict_delta(input copy_attempt_type w);
      int                   before_sum;
      int                   after_sum;
      logic [TAG_WIDTH-1:0] tgt;
      logic [TAG_WIDTH-1:0] src;
      logic [TAG_WIDTH-1:0] nbr_tag;
      kind_type             nbr_kind;
      before_sum = 0;
      after_sum = 0;
      tgt = w.target_tag & TAG_MASK;
      src = w.source_tag & TAG_MASK;
      for (int n = 0; n < NEIGHBOR_COUNT; n++) begin
         nbr_tag = w.neighbor_tags[TAG_WIDTH*n +: TAG_WIDTH] & TAG_MASK;
         nbr_kind = w.neighbor_types[KIND_WIDTH*n +: KIND_WIDTH];
         before_sum += contact_cost(tgt, nbr_tag, w.target_type, nbr_kind);
         after_sum += contact_cost(src, nbr_tag, w.source_type, nbr_kind);
      end
      return DELTA_WIDTH'(after_sum - before_sum);
   endfunction

   function automatic copy_attempt_type make_attempt(input logic [TAG_WIDTH-1:0] t_tag,
                                                     input kind_type t_kind,
                                                     input logic [TAG_WIDTH-1:0] s_tag,
                                                     input kind_type s_kind,
                                                     input logic [63:0] n_tags,
                                                     input logic [15:0] n_kinds);
      copy_attempt_type w;
      w.target_tag = t_tag;
      w.target_type = t_kind;
      w.source_tag = s_tag;
      w.source_type = s_kind;
      w.neighbor_tags = n_tags;
      w.neighbor_types = n_kinds;
      return w;
   endfunction

   function automatic kind_type random_kind();
      return ($urandom_range(7) == 0) ? kind_type'($urandom) : kind_type'($urandom_range(2));
   endfunction

   function automatic copy_attempt_type random_attempt();
      copy_attempt_type w;
      w.target_tag = ($urandom_range(3) == 0) ? '0 : TAG_WIDTH'($urandom);
      case ($urandom_range(3))
         0:       w.source_tag = '0;
         1:       w.source_tag = w.target_tag;
         default: w.source_tag = TAG_WIDTH'($urandom);
      endcase
      w.target_type = random_kind();
      w.source_type = random_kind();
      if ($urandom_range(9) == 0) begin
         w.neighbor_tags = {$urandom, $urandom};
         w.neighbor_types = 16'($urandom);
      end else begin
         for (int n = 0; n < NEIGHBOR_COUNT; n++) begin
            case ($urandom_range(5))
               0:       w.neighbor_tags[TAG_WIDTH*n +: TAG_WIDTH] = '0;
               1, 2:    w.neighbor_tags[TAG_WIDTH*n +: TAG_WIDTH] = w.target_tag;
               3:       w.neighbor_tags[TAG_WIDTH*n +: TAG_WIDTH] = w.source_tag;
               default: w.neighbor_tags[TAG_WIDTH*n +: TAG_WIDTH] = TAG_WIDTH'($urandom);
            endcase
            w.neighbor_types[KIND_WIDTH*n +: KIND_WIDTH] = random_kind();
         end
      end
      return w;
   endfunction

   function automatic energy_word_type random_energy();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return energy_word_type'($urandom);
      endcase
   endfunction

   function automatic bit pause_chance(input pacing_mode_type solo);
      if (pacing == solo) begin
         return $urandom_range(99) < 88;
      end
      if (pacing == PACE_BOTH) begin
         return $urandom_range(99) < 28;
      end
      return 1'b0;
   endfunction

   always @(negedge clock) begin : request_driver
      copy_attempt_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_attempts.size() != 0 && !pause_chance(PACE_SENDER_IDLE)) begin
            w = pending_attempts.pop_front();
            req_if.valid <= 1'b1;
            req_if.target_tag <= w.target_tag;
            req_if.target_type <= w.target_type;
            req_if.source_tag <= w.source_tag;
            req_if.source_type <= w.source_type;
            req_if.neighbor_tags <= w.neighbor_tags;
            req_if.neighbor_types <= w.neighbor_types;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : response_pacer
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !pause_chance(PACE_RECEIVER_STALL);
      end
   end

   always @(posedge clock) begin : delta_monitor
      copy_attempt_type              w;
      logic signed [DELTA_WIDTH-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.addr)
               pced_pkg::REG_CM_CM:     adhesion.cm_cm = csr_if.data;
               pced_pkg::REG_FB_FB:     adhesion.fb_fb = csr_if.data;
               pced_pkg::REG_FB_CM:     adhesion.fb_cm = csr_if.data;
               pced_pkg::REG_CM_MEDIUM: adhesion.cm_medium = csr_if.data;
               pced_pkg::REG_FB_MEDIUM: adhesion.fb_medium = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            w = make_attempt(req_if.target_tag, req_if.target_type, req_if.source_tag,
                             req_if.source_type, req_if.neighbor_tags, req_if.neighbor_types);
            expected_deltas.push_back(predict_delta(w));
            attempts_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            deltas_checked++;
            if (expected_deltas.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected energy_delta word, expected none, actual %0d",
                        $time, rsp_if.energy_delta);
            end else begin
               want = expected_deltas.pop_front();
               if (rsp_if.energy_delta !== want) begin
                  mismatch_count++;
                  $display("%0t: energy_delta mismatch, expected %0d, actual %0d",
                           $time, want, rsp_if.energy_delta);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("potts_contact_energy_delta regression: fail");
      $finish;
   end

   task automatic csr_write(input csr_addr_type index, input energy_word_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr <= index;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic program_energies(input energy_type values, input bit with_stray);
      csr_write(pced_pkg::REG_CM_CM, values.cm_cm);
      csr_write(pced_pkg::REG_FB_FB, values.fb_fb);
      csr_write(pced_pkg::REG_FB_CM, values.fb_cm);
      csr_write(pced_pkg::REG_CM_MEDIUM, values.cm_medium);
      csr_write(pced_pkg::REG_FB_MEDIUM, values.fb_medium);
      if (with_stray) begin
         csr_write(csr_addr_type'($urandom_range(255, REG_COUNT)), energy_word_type'($urandom));
      end
      @(negedge clock);
      csr_if.valid <= 1'b0;
      settings_programmed++;
   endtask

   task automatic wait_until_drained();
      while (pending_attempts.size() != 0 || req_if.valid || expected_deltas.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      energy_type values;
      adhesion = '0;
      pacing = PACE_FREE;
      mismatch_count = 0;
      attempts_accepted = 0;
      deltas_checked = 0;
      settings_programmed = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.target_tag = '0;
      req_if.target_type = '0;
      req_if.source_tag = '0;
      req_if.source_type = '0;
      req_if.neighbor_tags = '0;
      req_if.neighbor_types = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.addr = '0;
      csr_if.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset energies every copy attempt is free.
      pending_attempts.push_back(make_attempt(8'd5, 2'd1, 8'd0, 2'd0, {8{8'h07}}, 16'h5555));
      pending_attempts.push_back(make_attempt(8'd0, 2'd2, 8'd255, 2'd3, '1, '1));
      settle();

      // Weights in powers of nine keep every register's share of a sum apart.
      values.cm_cm = 16'd1;
      values.fb_fb = 16'd9;
      values.fb_cm = 16'd81;
      values.cm_medium = 16'd729;
      values.fb_medium = 16'd6561;
      program_energies(values, 1'b1);
      pending_attempts.push_back(make_attempt(8'd0, 2'd0, 8'd0, 2'd0, '0, '0));
      pending_attempts.push_back(make_attempt(8'd0, 2'd0, 8'd3, 2'd1,
         {8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10}, 16'h5555));
      pending_attempts.push_back(make_attempt(8'd9, 2'd2, 8'd9, 2'd2,
         {8'd0, 8'd9, 8'd22, 8'd23, 8'd0, 8'd9, 8'd24, 8'd25}, 16'h9A65));
      pending_attempts.push_back(make_attempt(8'd20, 2'd2, 8'd0, 2'd1, {8{8'd20}}, 16'hAAAA));
      pending_attempts.push_back(make_attempt(8'd1, 2'd1, 8'd2, 2'd2,
         {8'd37, 8'd36, 8'd35, 8'd0, 8'd33, 8'd32, 8'd31, 8'd30}, 16'h9999));
      pending_attempts.push_back(make_attempt(8'd40, 2'd3, 8'd41, 2'd3,
         {8'd57, 8'd56, 8'd55, 8'd54, 8'd53, 8'd52, 8'd51, 8'd50}, 16'h7DF7));
      pending_attempts.push_back(make_attempt(8'd60, 2'd0, 8'd0, 2'd1,
         {8'd67, 8'd0, 8'd65, 8'd60, 8'd63, 8'd62, 8'd0, 8'd61}, 16'h0140));
      pending_attempts.push_back(make_attempt(8'd255, 2'd2, 8'd254, 2'd1,
         {8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00}, 16'h6969));
      pending_attempts.push_back(make_attempt(8'd0, 2'd0, 8'd255, 2'd3, '1, '1));
      pending_attempts.push_back(make_attempt(8'd0, 2'd2, 8'd0, 2'd1,
         {8'd0, 8'd4, 8'd0, 8'd5, 8'd6, 8'd0, 8'd7, 8'd8}, 16'hE4E4));
      pending_attempts.push_back(make_attempt(8'd12, 2'd1, 8'd13, 2'd1,
         {8'd12, 8'd13, 8'd14, 8'd0, 8'd12, 8'd13, 8'd15, 8'd16}, 16'h9455));
      settle();

      // Largest energies give the extremes of the delta in both directions.
      values = '1;
      program_energies(values, 1'b0);
      pending_attempts.push_back(make_attempt(8'd7, 2'd1, 8'd0, 2'd2, {8{8'd7}}, 16'h5555));
      pending_attempts.push_back(make_attempt(8'd0, 2'd2, 8'd7, 2'd1, {8{8'd7}}, 16'hAAAA));
      pending_attempts.push_back(make_attempt(8'd3, 2'd1, 8'd4, 2'd2, {8{8'd4}}, 16'h5555));
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pacing = pacing_mode_type'(phase % 4);
         values.cm_cm = random_energy();
         values.fb_fb = random_energy();
         values.fb_cm = random_energy();
         values.cm_medium = random_energy();
         values.fb_medium = random_energy();
         program_energies(values, phase[0]);
         for (int i = 0; i < PHASE_WORDS / 2; i++) begin
            pending_attempts.push_back(random_attempt());
         end
         // The sender runs dry here until every pending delta has come back.
         wait_until_drained();
         for (int i = 0; i < PHASE_WORDS / 2; i++) begin
            pending_attempts.push_back(random_attempt());
         end
         settle();
      end

      $display("Ran %0d copy attempts (%0d deltas checked) over %0d energy settings,",
               attempts_accepted, deltas_checked, settings_programmed);
      $display("with free, sender-idle, receiver-stall and mixed pacing; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("potts_contact_energy_delta regression: pass");
      end else begin
         $display("potts_contact_energy_delta regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/pced_pkg.sv
hw/rtl/pced_if.sv
hw/rtl/pced_csr.sv
hw/rtl/pced_pipe.sv
hw/rtl/potts_contact_energy_delta.sv
tb/tb_potts_contact_energy_delta.sv
